// ----- hdl/dmc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmc_pkg
// Types and codes shared by the door motor controller modules.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_TIMEOUT  = 2'd0,
    REG_TRAVEL_TIMEOUT = 2'd1
  } reg_index_t;

  localparam logic [CFG_W-1:0] START_TIMEOUT_RESET  = 16'd1;
  localparam logic [CFG_W-1:0] TRAVEL_TIMEOUT_RESET = 16'd10;

  typedef enum logic [1:0] {
    DRIVE_STOP  = 2'd0,
    DRIVE_OPEN  = 2'd1,
    DRIVE_CLOSE = 2'd2
  } motor_t;

  typedef enum logic [3:0] {
    MODE_OPEN           = 4'd0,
    MODE_OPENING_START  = 4'd1,
    MODE_OPENING_TRAVEL = 4'd2,
    MODE_CLOSED         = 4'd3,
    MODE_CLOSING_START  = 4'd4,
    MODE_CLOSING_TRAVEL = 4'd5,
    MODE_STOPPED_MID    = 4'd6,
    MODE_ERR_TO_OPEN    = 4'd7,
    MODE_ERR_TO_CLOSED  = 4'd8
  } mode_t;

  typedef struct packed {
    logic button_pin;
    logic open_pin;
    logic closed_pin;
    logic tick;
  } in_word_t;

  typedef struct packed {
    motor_t motor_cmd;
    logic   lamp_ok;
    logic   lamp_busy;
    logic   lamp_error;
    mode_t  door_state;
  } out_word_t;

  // Timer control from the state machine
  typedef struct packed {
    logic step;        // commit one sample
    logic tick;        // time unit elapsed before this sample
    logic start;       // reload and arm
    logic sel_travel;  // reload from travel timeout, else start timeout
  } timer_ctrl_t;

endpackage

// ----- hdl/dmc_timer.sv -----
// ----------------------------------------------------------------------------
// dmc_timer
// One-shot timeout counter with a sticky expired flag.
// ----------------------------------------------------------------------------
module dmc_timer import dmc_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  timer_ctrl_t      ctrl,
  input  logic [CFG_W-1:0] start_timeout,
  input  logic [CFG_W-1:0] travel_timeout,
  output logic             expired_now
);

  logic [TIMER_BITS-1:0] time_left;
  logic [TIMER_BITS-1:0] time_left_next;
  logic                  timer_armed;
  logic                  timer_armed_next;
  logic                  timer_expired;
  logic                  timer_expired_next;
  logic [TIMER_BITS-1:0] ticked_left;
  logic                  ticked_armed;
  logic                  ticked_expired;
  logic [TIMER_BITS-1:0] load_val;

  assign load_val = ctrl.sel_travel ? TIMER_BITS'(travel_timeout)
                                    : TIMER_BITS'(start_timeout);

  // Apply the tick first; the state machine sees the result
  always_comb begin
    ticked_left    = time_left;
    ticked_armed   = timer_armed;
    ticked_expired = timer_expired;
    if (ctrl.tick && timer_armed) begin
      ticked_left = time_left - TIMER_BITS'(1);
      if (ticked_left == '0) begin
        ticked_expired = 1'b1;
        ticked_armed   = 1'b0;
      end
    end
  end

  assign expired_now = ticked_expired;

  always_comb begin
    time_left_next     = ticked_left;
    timer_armed_next   = ticked_armed;
    timer_expired_next = ticked_expired;
    if (ctrl.start) begin
      time_left_next     = load_val;
      timer_expired_next = (load_val == '0);
      timer_armed_next   = (load_val != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_left     <= '0;
      timer_armed   <= 1'b0;
      timer_expired <= 1'b0;
    end else if (ctrl.step) begin
      time_left     <= time_left_next;
      timer_armed   <= timer_armed_next;
      timer_expired <= timer_expired_next;
    end
  end

  // An armed timer never holds zero
  assert property (@(posedge clk) disable iff (rst)
    timer_armed |-> time_left != '0)
    else $error("armed timer holds zero");

  // Armed and expired exclude each other
  assert property (@(posedge clk) disable iff (rst)
    !(timer_armed && timer_expired))
    else $error("timer armed and expired at once");

endmodule

// ----- hdl/dmc_fsm.sv -----
// ----------------------------------------------------------------------------
// dmc_fsm
// Door state machine: press detect, sensor and timeout priority, lamps.
// ----------------------------------------------------------------------------
module dmc_fsm import dmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  in_word_t    item,
  input  logic        expired_now,
  output timer_ctrl_t timer_ctrl,
  output out_word_t   result
);

  mode_t  door_mode;
  mode_t  door_mode_next;
  motor_t motor_drive;
  motor_t motor_drive_next;
  logic   button_last;
  logic   press;
  logic   at_open;
  logic   at_closed;
  logic   start;
  logic   sel_travel;

  assign press     = button_last && !item.button_pin;
  assign at_open   = !item.open_pin;
  assign at_closed = !item.closed_pin;

  // Next state: press beats sensors, sensors beat the timeout
  always_comb begin
    door_mode_next   = door_mode;
    motor_drive_next = motor_drive;
    start            = 1'b0;
    sel_travel       = 1'b0;
    unique case (door_mode)
      MODE_OPEN: begin
        if (press) begin
          motor_drive_next = DRIVE_CLOSE;
          start            = 1'b1;
          door_mode_next   = MODE_CLOSING_START;
        end
      end
      MODE_CLOSING_START: begin
        priority if (press) begin
          motor_drive_next = DRIVE_STOP;
          door_mode_next   = MODE_STOPPED_MID;
        end else if (at_closed) begin
          motor_drive_next = DRIVE_STOP;
          door_mode_next   = MODE_CLOSED;
        end else if (!at_open) begin
          start          = 1'b1;
          sel_travel     = 1'b1;
          door_mode_next = MODE_CLOSING_TRAVEL;
        end else if (expired_now) begin
          motor_drive_next = DRIVE_STOP;
          door_mode_next   = MODE_ERR_TO_OPEN;
        end
      end
      MODE_CLOSING_TRAVEL: begin
        priority if (press) begin
          motor_drive_next = DRIVE_STOP;
          door_mode_next   = MODE_STOPPED_MID;
        end else if (at_closed) begin
          motor_drive_next = DRIVE_STOP;
          door_mode_next   = MODE_CLOSED;
        end else if (expired_now) begin
          motor_drive_next = DRIVE_STOP;
          door_mode_next   = MODE_ERR_TO_OPEN;
        end
      end
      MODE_CLOSED: begin
        priority if (press) begin
          motor_drive_next = DRIVE_OPEN;
          start            = 1'b1;
          door_mode_next   = MODE_OPENING_START;
        end else if (!at_closed) begin
          door_mode_next = MODE_ERR_TO_OPEN;
        end
      end
      MODE_STOPPED_MID: begin
        if (press) begin
          motor_drive_next = DRIVE_OPEN;
          start            = 1'b1;
          door_mode_next   = MODE_OPENING_START;
        end
      end
      MODE_OPENING_START: begin
        priority if (press || at_open) begin
          motor_drive_next = DRIVE_STOP;
          door_mode_next   = MODE_OPEN;
        end else if (!at_closed) begin
          start          = 1'b1;
          sel_travel     = 1'b1;
          door_mode_next = MODE_OPENING_TRAVEL;
        end else if (expired_now) begin
          motor_drive_next = DRIVE_STOP;
          door_mode_next   = MODE_ERR_TO_CLOSED;
        end
      end
      MODE_OPENING_TRAVEL: begin
        priority if (press || at_open) begin
          motor_drive_next = DRIVE_STOP;
          door_mode_next   = MODE_OPEN;
        end else if (expired_now) begin
          motor_drive_next = DRIVE_STOP;
          door_mode_next   = MODE_ERR_TO_CLOSED;
        end
      end
      MODE_ERR_TO_OPEN: begin
        if (press) begin
          door_mode_next = MODE_OPEN;
        end
      end
      MODE_ERR_TO_CLOSED: begin
        if (press) begin
          door_mode_next = MODE_STOPPED_MID;
        end
      end
      default: begin
        motor_drive_next = DRIVE_STOP;
        door_mode_next   = MODE_OPEN;
      end
    endcase
  end

  // Outputs follow the state just entered
  always_comb begin
    result.motor_cmd  = motor_drive_next;
    result.door_state = door_mode_next;
    result.lamp_ok    = (door_mode_next == MODE_OPEN) || (door_mode_next == MODE_CLOSED) ||
                        (door_mode_next == MODE_STOPPED_MID);
    result.lamp_busy  = (door_mode_next == MODE_OPENING_START) ||
                        (door_mode_next == MODE_OPENING_TRAVEL) ||
                        (door_mode_next == MODE_CLOSING_START) ||
                        (door_mode_next == MODE_CLOSING_TRAVEL);
    result.lamp_error = (door_mode_next == MODE_ERR_TO_OPEN) ||
                        (door_mode_next == MODE_ERR_TO_CLOSED);
  end

  assign timer_ctrl.step       = step;
  assign timer_ctrl.tick       = item.tick;
  assign timer_ctrl.start      = start;
  assign timer_ctrl.sel_travel = sel_travel;

  always_ff @(posedge clk) begin
    if (rst) begin
      door_mode   <= MODE_OPEN;
      motor_drive <= DRIVE_STOP;
      button_last <= 1'b1;
    end else if (step) begin
      door_mode   <= door_mode_next;
      motor_drive <= motor_drive_next;
      button_last <= item.button_pin;
    end
  end

  // Motor runs only in the moving states
  assert property (@(posedge clk) disable iff (rst)
    (motor_drive != DRIVE_STOP) |->
      (door_mode == MODE_OPENING_START || door_mode == MODE_OPENING_TRAVEL ||
       door_mode == MODE_CLOSING_START || door_mode == MODE_CLOSING_TRAVEL))
    else $error("motor running outside a moving state");

  // Opening states drive open, closing states drive close
  assert property (@(posedge clk) disable iff (rst)
    (door_mode == MODE_OPENING_START || door_mode == MODE_OPENING_TRAVEL) |->
      motor_drive == DRIVE_OPEN)
    else $error("opening without open drive");

  assert property (@(posedge clk) disable iff (rst)
    (door_mode == MODE_CLOSING_START || door_mode == MODE_CLOSING_TRAVEL) |->
      motor_drive == DRIVE_CLOSE)
    else $error("closing without close drive");

endmodule

// ----- hdl/door_motor_controller.sv -----
// ----------------------------------------------------------------------------
// door_motor_controller
// Nine-state door motor controller over debounced pin samples.
// ----------------------------------------------------------------------------
// Takes one pin sample word per cycle while the sink keeps out_ready high, and
// returns one result word per sample. A word passes an input register, then the
// state update and the timer, which are combinational, then a result register
// that drives out_valid. The sustained rate is one word per clock while
// out_ready stays high. Timeout registers are written
// over the cfg port, which is always ready; write them only while idle.
module door_motor_controller import dmc_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic             in_full;
  in_word_t         in_word;
  logic             out_full;
  out_word_t        out_word;
  logic             advance;
  logic [CFG_W-1:0] start_timeout;
  logic [CFG_W-1:0] travel_timeout;
  timer_ctrl_t      timer_ctrl;
  logic             expired_now;
  out_word_t        result;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_full || out_ready);
  assign in_ready  = !in_full || advance;
  assign out_valid = out_full;
  assign out_data  = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_timeout  <= START_TIMEOUT_RESET;
      travel_timeout <= TRAVEL_TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_TIMEOUT:  start_timeout  <= cfg_data;
        REG_TRAVEL_TIMEOUT: travel_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  dmc_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (in_word),
    .expired_now (expired_now),
    .timer_ctrl  (timer_ctrl),
    .result      (result)
  );

  dmc_timer #(
    .TIMER_BITS (TIMER_BITS)
  ) u_timer (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (timer_ctrl),
    .start_timeout  (start_timeout),
    .travel_timeout (travel_timeout),
    .expired_now    (expired_now)
  );

  // Exactly one lamp lit on every result word
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({out_data.lamp_ok, out_data.lamp_busy, out_data.lamp_error}))
    else $error("lamps not one-hot");

  // Stall only when both registers are full and the sink holds off
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_full && out_full && !out_ready))
    else $error("input stalled without back pressure");

  // A word that advanced shows up as a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced word lost");

endmodule
